// ===== rtl/core/binary_cross_morphology_defines.svh =====
// Assertion macros for the binary cross morphology RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BINARY_CROSS_MORPHOLOGY_DEFINES_SVH
`define BINARY_CROSS_MORPHOLOGY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bcm_pkg.sv =====
// Shared types and constants of the binary cross morphology block.
// No dependencies; imported by every module of the block.
`default_nettype none

package bcm_pkg;

  // Fixed field widths.
  localparam int PIX_W   = 8;
  localparam int ROW_W   = 16;
  localparam int CFGW_W  = 11;
  localparam int CFGH_W  = 16;
  localparam int APB_A_W = 4;
  localparam int APB_D_W = 32;

  // Register indexes (word address bits of paddr).
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ERODE_MODE   = 2'd2;

  // Register reset values.
  localparam logic [CFGW_W-1:0] RST_IMAGE_WIDTH  = 11'd256;
  localparam logic [CFGH_W-1:0] RST_IMAGE_HEIGHT = 16'd256;

  // Pixel codes: bit CODE_NZ set for a nonzero pixel, bit CODE_FULL for 255.
  localparam int CODE_NZ   = 0;
  localparam int CODE_FULL = 1;
  localparam logic [PIX_W-1:0] PIX_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_OFF = 8'h00;

  // Queue depths (powers of two).
  localparam int IQ_DEPTH = 4;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Classification of one item, made by the front part.
  typedef struct packed {
    logic has_prev;   // a row lies above: result for the row above is due
    logic last_row;   // item is on the last row: its own result is due
    logic last_col;   // item is the last of its row
    logic act_up;     // row-above result: upper neighbor counts
    logic act_cur;    // row-above result: lower neighbor (this item) counts
    logic act_left;   // row-above result: left neighbor counts
    logic act_right;  // row-above result: right neighbor counts
    logic act_up_own; // own result: upper neighbor counts
  } bcm_flags_t;

  typedef struct packed {
    logic [1:0]       code;
    logic [ROW_W-1:0] row;
    bcm_flags_t       flags;
  } bcm_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [ROW_W-1:0] row;
    logic             done;
  } bcm_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bcm_fifo.sv =====
// Small registered queue between the front and back parts.
// Depends on bcm_pkg only for the project style; DEPTH must be a power of two.
`default_nettype none
`include "binary_cross_morphology_defines.svh"

module bcm_fifo import bcm_pkg::*; #(
  parameter int DEPTH  = 4,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `BCM_ASSERT_NEXT(a_fifo_fill, do_push && !do_pop, count_r == $past(count_r) + 1'b1, "fifo count did not grow on push")

endmodule

`default_nettype wire

// ===== rtl/core/bcm_outq.sv =====
// Result queue that takes up to two items per cycle and gives one.
// Depends on bcm_pkg; DEPTH must be a power of two and at least two.
`default_nettype none
`include "binary_cross_morphology_defines.svh"

module bcm_outq import bcm_pkg::*; #(
  parameter int DEPTH  = 4,
  parameter int DATA_W = 8,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n,
  input  logic [DATA_W-1:0] data0,
  input  logic [DATA_W-1:0] data1,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] head,
  output logic [CW-1:0]     count
);

  localparam int PW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_pop;

  assign empty  = (count_r == '0);
  assign do_pop = pop && !empty;
  assign head   = mem_r[rd_ptr_r];
  assign count  = count_r;

  // Pointers advance by the number of items written and read.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_n);
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CW'(push_n) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // The first item goes to the write pointer, a second one just after it.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= data0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + 1'b1] <= data1;
    end
  end

  `BCM_ASSERT_SAME(a_oq_room, push_n != 2'd0, ({1'b0, count_r} + push_n) <= DEPTH, "result queue overflow")
  `BCM_ASSERT_NEXT(a_oq_drain, do_pop && push_n == 2'd0, count_r == $past(count_r) - 1'b1, "result queue count did not drop on pop")

endmodule

`default_nettype wire

// ===== rtl/core/bcm_front.sv =====
// Front part: takes pixels, keeps the raster position and classifies each item.
// Depends on bcm_pkg for the item and flag structs.
`default_nettype none

module bcm_front import bcm_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int COL_W    = $clog2(MAX_WIDTH),
  localparam int IQ_W     = COL_W + $bits(bcm_item_t)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [PIX_W-1:0]  pixel,
  input  logic [CFGW_W-1:0] cfg_width,
  input  logic [CFGH_W-1:0] cfg_height,
  input  logic              q_full,
  output logic              q_push,
  output logic [IQ_W-1:0]   q_data
);

  localparam int MW_W = $clog2(MAX_WIDTH + 1);
  localparam int WE_W = (MW_W > CFGW_W) ? MW_W : CFGW_W;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WE_W-1:0]  w_eff;
  logic [ROW_W-1:0] h_eff;
  logic             wrap_in;
  logic [ROW_W-1:0] row_t;
  logic [COL_W-1:0] c;
  logic [ROW_W-1:0] r;
  logic [WE_W-1:0]  c1;
  logic [ROW_W:0]   r1;
  logic             c_in, r_in;
  bcm_item_t        item;

  assign q_push = push && !q_full;

  // Effective frame size: zero acts as one, width is capped at the line store size.
  always_comb begin
    if (cfg_width == '0) begin
      w_eff = WE_W'(1);
    end else if (WE_W'(cfg_width) > WE_W'(MAX_WIDTH)) begin
      w_eff = WE_W'(MAX_WIDTH);
    end else begin
      w_eff = WE_W'(cfg_width);
    end
    h_eff = (cfg_height == '0) ? ROW_W'(1) : cfg_height;
  end

  // Position of this item; stale counters after a size change start over.
  always_comb begin
    wrap_in = (WE_W'(col_r) >= w_eff);
    c       = wrap_in ? '0 : col_r;
    row_t   = wrap_in ? row_r + 1'b1 : row_r;
    r       = (row_t >= h_eff) ? '0 : row_t;
    c1      = WE_W'(c) + 1'b1;
    r1      = {1'b0, r} + 1'b1;
  end

  // Classify which results are due and which cross neighbors lie inside.
  always_comb begin
    c_in = (c != '0) && (c1 < w_eff);
    r_in = (r != '0) && (r1 < {1'b0, h_eff});
    item.code[CODE_NZ]    = (pixel != PIX_OFF);
    item.code[CODE_FULL]  = (pixel == PIX_ON);
    item.row              = r;
    item.flags.has_prev   = (r != '0);
    item.flags.last_row   = (r1 == {1'b0, h_eff});
    item.flags.last_col   = (c1 == w_eff);
    item.flags.act_up     = (r >= ROW_W'(3)) && c_in;
    item.flags.act_cur    = r_in && c_in;
    item.flags.act_left   = (c >= COL_W'(2)) && (r >= ROW_W'(2));
    item.flags.act_right  = ((c1 + 1'b1) < w_eff) && (r >= ROW_W'(2));
    item.flags.act_up_own = (r >= ROW_W'(2)) && c_in;
    q_data = {c, item};
  end

  // Advance the raster position on each accepted item.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (q_push) begin
      if (item.flags.last_col) begin
        col_nxt = '0;
        row_nxt = item.flags.last_row ? '0 : r1[ROW_W-1:0];
      end else begin
        col_nxt = c1[COL_W-1:0];
        row_nxt = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bcm_back.sv =====
// Back part: line store, window register and the dilate/erode decision.
// Depends on bcm_pkg; feeds bcm_outq with up to two results per item.
`default_nettype none
`include "binary_cross_morphology_defines.svh"

module bcm_back import bcm_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int COL_W    = $clog2(MAX_WIDTH),
  localparam int IQ_W     = COL_W + $bits(bcm_item_t),
  localparam int OQ_W     = COL_W + $bits(bcm_res_t)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                erode,
  input  logic                q_empty,
  input  logic [IQ_W-1:0]     q_data,
  output logic                q_pop,
  input  logic [OQ_CNT_W-1:0] oq_count,
  output logic [1:0]          oq_push_n,
  output logic [OQ_W-1:0]     oq_data0,
  output logic [OQ_W-1:0]     oq_data1
);

  // Each line store entry holds {older row code, recent row code}.
  logic [3:0]       line_mem [MAX_WIDTH];
  logic [3:0]       rda_r, rdb_r, byp_d_r;
  logic             byp_a_r, byp_b_r;
  logic [3:0]       line_a, line_b, wr_data;
  logic             s1_valid_r, s1_valid_nxt;
  logic [COL_W-1:0] s1_col_r;
  bcm_item_t        s1_item_r;
  logic [1:0]       win_r, win_nxt;
  logic             s1_retire, advance;
  logic [COL_W-1:0] col_in, addr_a, addr_b;
  bcm_item_t        item_in;
  logic [1:0]       above, older, right;
  bcm_flags_t       fl;
  bcm_res_t         res_a, res_b;

  // Cross decision; nz and full carry bits of up, lower, left, right codes.
  function automatic logic decide(input logic       erode_m,
                                  input logic [1:0] center,
                                  input logic [3:0] nz,
                                  input logic [3:0] full,
                                  input logic [3:0] act);
    logic hit;
    if (erode_m) begin
      hit = center[CODE_FULL] && !(|(act & ~nz));
    end else begin
      hit = center[CODE_NZ] || (|(act & full));
    end
    return hit;
  endfunction

  // Stage handshake: an item retires once the result queue has room for two.
  always_comb begin
    s1_retire    = s1_valid_r && (oq_count <= OQ_CNT_W'(OQ_DEPTH - 2));
    advance      = !s1_valid_r || s1_retire;
    q_pop        = advance && !q_empty;
    s1_valid_nxt = advance ? !q_empty : s1_valid_r;
  end

  // Read addresses of the incoming item: its own column and the one to its right (column zero for the last column).
  always_comb begin
    col_in  = q_data[IQ_W-1 -: COL_W];
    item_in = bcm_item_t'(q_data[$bits(bcm_item_t)-1:0]);
    addr_a  = col_in;
    addr_b  = item_in.flags.last_col ? '0 : col_in + 1'b1;
  end

  // Read data with forwarding of the write that retires in the same cycle.
  always_comb begin
    line_a  = byp_a_r ? byp_d_r : rda_r;
    line_b  = byp_b_r ? byp_d_r : rdb_r;
    above   = line_a[1:0];
    older   = line_a[3:2];
    right   = line_b[1:0];
    wr_data = {above, s1_item_r.code};
    win_nxt = s1_retire ? above : win_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      win_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      win_r      <= win_nxt;
    end
  end

  // Line store and stage payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rda_r     <= line_mem[addr_a];
      rdb_r     <= line_mem[addr_b];
      byp_a_r   <= s1_retire && (s1_col_r == addr_a);
      byp_b_r   <= s1_retire && (s1_col_r == addr_b);
      byp_d_r   <= wr_data;
      s1_col_r  <= col_in;
      s1_item_r <= item_in;
    end
    if (s1_retire) begin
      line_mem[s1_col_r] <= wr_data;
    end
  end

  // Results: the row above first, then the item's own row on the last row.
  always_comb begin
    fl = s1_item_r.flags;
    res_a.pixel = decide(erode, above,
                         {older[CODE_NZ], s1_item_r.code[CODE_NZ], win_r[CODE_NZ],
                          right[CODE_NZ]},
                         {older[CODE_FULL], s1_item_r.code[CODE_FULL], win_r[CODE_FULL],
                          right[CODE_FULL]},
                         {fl.act_up, fl.act_cur, fl.act_left, fl.act_right})
                  ? PIX_ON : PIX_OFF;
    res_a.row  = s1_item_r.row - 1'b1;
    res_a.done = 1'b0;
    res_b.pixel = decide(erode, s1_item_r.code,
                         {above[CODE_NZ], 3'b000},
                         {above[CODE_FULL], 3'b000},
                         {fl.act_up_own, 3'b000})
                  ? PIX_ON : PIX_OFF;
    res_b.row  = s1_item_r.row;
    res_b.done = fl.last_col;
    oq_push_n  = s1_retire ? (2'(fl.has_prev) + 2'(fl.last_row)) : 2'd0;
    oq_data0   = fl.has_prev ? {s1_col_r, res_a} : {s1_col_r, res_b};
    oq_data1   = {s1_col_r, res_b};
  end

  `BCM_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_retire, s1_valid_r && $stable(s1_item_r) && $stable(s1_col_r), "stalled item changed")

endmodule

`default_nettype wire

// ===== rtl/core/binary_cross_morphology.sv =====
// Top level of the binary cross morphology block: registers and queue wiring.
// Depends on bcm_pkg, bcm_front, bcm_fifo, bcm_back and bcm_outq.
//
//   Channel   Ports                                 Handshake
//   input     push, full, in_pixel_value            accept on push & !full
//   result    pop, empty, out_*                     accept on pop & !empty
//   config    psel, penable, pwrite, paddr, pwdata  write on access phase
//
// One item per cycle is taken unless the input queue is full; on the last row
// of a frame each item gives two results and the one-per-cycle result port
// then sets the pace. An item goes through the input queue and the back stage
// register, and its results through the result queue. The line store has a
// single write port shared by all items, one per cycle while the result queue
// has room. Reset clears counters, queues and control registers, not the line
// store. Either side may stall at any time; the queues absorb the difference.
`default_nettype none

module binary_cross_morphology import bcm_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int COL_W    = $clog2(MAX_WIDTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               push,
  output logic               full,
  input  logic [PIX_W-1:0]   in_pixel_value,
  // Result channel.
  output logic               empty,
  input  logic               pop,
  output logic [PIX_W-1:0]   out_result_pixel,
  output logic [COL_W-1:0]   out_column,
  output logic [ROW_W-1:0]   out_row,
  output logic               out_frame_done,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_A_W-1:0] paddr,
  input  logic [APB_D_W-1:0] pwdata,
  output logic [APB_D_W-1:0] prdata,
  output logic               pready
);

  localparam int IQ_W = COL_W + $bits(bcm_item_t);
  localparam int OQ_W = COL_W + $bits(bcm_res_t);

  logic [CFGW_W-1:0]   cfg_width_r;
  logic [CFGH_W-1:0]   cfg_height_r;
  logic                cfg_erode_r;
  logic [1:0]          reg_idx;
  logic                cfg_wr;
  logic                iq_push, iq_full, iq_pop, iq_empty;
  logic [IQ_W-1:0]     iq_wdata, iq_rdata;
  logic [1:0]          oq_push_n;
  logic [OQ_W-1:0]     oq_data0, oq_data1, oq_head;
  logic [OQ_CNT_W-1:0] oq_count;
  bcm_res_t            head_res;

  // Register file.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_A_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RST_IMAGE_WIDTH;
      cfg_height_r <= RST_IMAGE_HEIGHT;
      cfg_erode_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  cfg_width_r  <= pwdata[CFGW_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height_r <= pwdata[CFGH_W-1:0];
        REG_ERODE_MODE:   cfg_erode_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_D_W'(cfg_width_r);
      REG_IMAGE_HEIGHT: prdata = APB_D_W'(cfg_height_r);
      REG_ERODE_MODE:   prdata = APB_D_W'(cfg_erode_r);
      default:          prdata = '0;
    endcase
  end

  // Front part: position tracking and classification.
  assign full = iq_full;

  bcm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pixel      (in_pixel_value),
    .cfg_width  (cfg_width_r),
    .cfg_height (cfg_height_r),
    .q_full     (iq_full),
    .q_push     (iq_push),
    .q_data     (iq_wdata)
  );

  // Queue between the front and back parts.
  bcm_fifo #(.DEPTH(IQ_DEPTH), .DATA_W(IQ_W)) u_iq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (iq_push),
    .wdata (iq_wdata),
    .full  (iq_full),
    .pop   (iq_pop),
    .rdata (iq_rdata),
    .empty (iq_empty)
  );

  // Back part: line store and decision.
  bcm_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .erode     (cfg_erode_r),
    .q_empty   (iq_empty),
    .q_data    (iq_rdata),
    .q_pop     (iq_pop),
    .oq_count  (oq_count),
    .oq_push_n (oq_push_n),
    .oq_data0  (oq_data0),
    .oq_data1  (oq_data1)
  );

  // Result queue.
  bcm_outq #(.DEPTH(OQ_DEPTH), .DATA_W(OQ_W)) u_oq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (oq_push_n),
    .data0  (oq_data0),
    .data1  (oq_data1),
    .pop    (pop),
    .empty  (empty),
    .head   (oq_head),
    .count  (oq_count)
  );

  // Unpack the oldest result onto the ports.
  always_comb begin
    head_res         = bcm_res_t'(oq_head[$bits(bcm_res_t)-1:0]);
    out_column       = oq_head[OQ_W-1 -: COL_W];
    out_result_pixel = head_res.pixel;
    out_row          = head_res.row;
    out_frame_done   = head_res.done;
  end

endmodule

`default_nettype wire
